>>> hw/rtl/ieu_pkg.sv
// Package for the integer execute unit: codes, pipeline record type and divider step.
`timescale 1ns / 1ps
package ieu_pkg;

    localparam int XLEN = 32;
    localparam int DIV_STAGES = XLEN;

    localparam logic [1:0] KIND_ARITH = 2'd0;
    localparam logic [1:0] KIND_MULDIV = 2'd1;
    localparam logic [1:0] KIND_BRANCH = 2'd2;
    localparam logic [1:0] KIND_INDEX = 2'd3;

    localparam logic [2:0] ALU_AND = 3'd0;
    localparam logic [2:0] ALU_OR = 3'd1;
    localparam logic [2:0] ALU_XOR = 3'd2;
    localparam logic [2:0] ALU_SHIFT = 3'd3;
    localparam logic [2:0] ALU_ADD = 3'd4;
    localparam logic [2:0] ALU_SUB = 3'd5;
    localparam logic [2:0] ALU_SLT = 3'd6;
    localparam logic [2:0] ALU_SLTU = 3'd7;

    localparam logic [1:0] SHV_LEFT = 2'd0;
    localparam logic [1:0] SHV_ZERO = 2'd1;
    localparam logic [1:0] SHV_LOGIC_RIGHT = 2'd2;
    localparam logic [1:0] SHV_ARITH_RIGHT = 2'd3;

    localparam logic [2:0] MD_MUL = 3'd0;
    localparam logic [2:0] MD_DIVU = 3'd4;
    localparam logic [2:0] MD_DIV = 3'd5;
    localparam logic [2:0] MD_REMU = 3'd6;
    localparam logic [2:0] MD_REM = 3'd7;

    localparam logic [2:0] BR_EQ = 3'd0;
    localparam logic [2:0] BR_NE = 3'd1;
    localparam logic [2:0] BR_LT = 3'd2;
    localparam logic [2:0] BR_GE = 3'd3;
    localparam logic [2:0] BR_LTU = 3'd4;
    localparam logic [2:0] BR_GEU = 3'd5;

    localparam logic [2:0] IDX_X1 = 3'd0;
    localparam logic [2:0] IDX_X2 = 3'd1;
    localparam logic [2:0] IDX_X4 = 3'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      op;
        logic [XLEN-1:0] dividend_raw;
        logic            div_zero;
        logic            neg_quo;
        logic            neg_rem;
        logic [XLEN-1:0] dvsr;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] res;
        logic            fault;
    } pipe_t;

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t       n;
        logic [XLEN:0] trial;
        logic [XLEN:0] diff;
        n = p;
        trial = {p.rem, p.quo[XLEN-1]};
        diff = trial - {1'b0, p.dvsr};
        if (!diff[XLEN]) begin
            n.rem = diff[XLEN-1:0];
            n.quo = {p.quo[XLEN-2:0], 1'b1};
        end else begin
            n.rem = trial[XLEN-1:0];
            n.quo = {p.quo[XLEN-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/integer_execute_unit.sv
// Integer execute unit: ALU, multiply, pipelined divide, branch compare, index scale.
// Pipeline: entry register loaded on the accepting edge, 32 divider stages,
//   output stage.
// Throughput: one transaction per cycle; the whole pipeline holds while the
//   output register is full and not taken.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
module integer_execute_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic [2:0]                s_op,
    input  logic signed [ieu_pkg::XLEN-1:0] s_operand_a,
    input  logic signed [ieu_pkg::XLEN-1:0] s_operand_b,
    input  logic [1:0]                s_shift_variant,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ieu_pkg::XLEN-1:0] m_result,
    output logic                      m_index_fault
);
    import ieu_pkg::*;

    pipe_t           pipe_reg   [DIV_STAGES+1];
    logic            pvalid_reg [DIV_STAGES+1];
    pipe_t           entry_next;
    logic            adv;
    logic            m_valid_reg;
    logic [XLEN-1:0] m_result_reg;
    logic            m_fault_reg;
    logic [XLEN-1:0] res_next;
    logic [XLEN-1:0] a_u;
    logic [XLEN-1:0] b_u;
    logic [XLEN-1:0] prod;
    logic            sgn_div;
    pipe_t           last;
    logic [XLEN-1:0] fin_res;

    assign adv = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign a_u = s_operand_a;
    assign b_u = s_operand_b;
    assign prod = a_u * b_u;

    always_comb begin
        res_next = '0;
        unique case (s_kind)
            KIND_ARITH: begin
                unique case (s_op)
                    ALU_AND: res_next = a_u & b_u;
                    ALU_OR:  res_next = a_u | b_u;
                    ALU_XOR: res_next = a_u ^ b_u;
                    ALU_SHIFT: begin
                        unique case (s_shift_variant)
                            SHV_LEFT:        res_next = a_u << b_u[4:0];
                            SHV_ZERO:        res_next = '0;
                            SHV_LOGIC_RIGHT: res_next = a_u >> b_u[4:0];
                            SHV_ARITH_RIGHT: res_next = s_operand_a >>> b_u[4:0];
                            default:         res_next = '0;
                        endcase
                    end
                    ALU_ADD:  res_next = a_u + b_u;
                    ALU_SUB:  res_next = a_u - b_u;
                    ALU_SLT:  res_next = {{(XLEN-1){1'b0}}, s_operand_a < s_operand_b};
                    ALU_SLTU: res_next = {{(XLEN-1){1'b0}}, a_u < b_u};
                    default:  res_next = '0;
                endcase
            end
            KIND_MULDIV: res_next = (s_op == MD_MUL) ? prod : '0;
            KIND_BRANCH: begin
                unique case (s_op)
                    BR_EQ:   res_next = {{(XLEN-1){1'b0}}, a_u == b_u};
                    BR_NE:   res_next = {{(XLEN-1){1'b0}}, a_u != b_u};
                    BR_LT:   res_next = {{(XLEN-1){1'b0}}, s_operand_a < s_operand_b};
                    BR_GE:   res_next = {{(XLEN-1){1'b0}}, s_operand_a >= s_operand_b};
                    BR_LTU:  res_next = {{(XLEN-1){1'b0}}, a_u < b_u};
                    BR_GEU:  res_next = {{(XLEN-1){1'b0}}, a_u >= b_u};
                    default: res_next = {{(XLEN-1){1'b0}}, 1'b1};
                endcase
            end
            KIND_INDEX: begin
                unique case (s_op)
                    IDX_X1:  res_next = a_u;
                    IDX_X2:  res_next = {a_u[XLEN-2:0], 1'b0};
                    IDX_X4:  res_next = {a_u[XLEN-3:0], 2'b00};
                    default: res_next = '0;
                endcase
            end
            default: res_next = '0;
        endcase
    end

    // Entry record: operand magnitudes for the divider, sign fixes for the end
    always_comb begin
        sgn_div = (s_op == MD_DIV) || (s_op == MD_REM);
        entry_next.kind = s_kind;
        entry_next.op = s_op;
        entry_next.dividend_raw = a_u;
        entry_next.div_zero = (b_u == '0);
        entry_next.neg_quo = sgn_div && (a_u[XLEN-1] != b_u[XLEN-1]);
        entry_next.neg_rem = sgn_div && a_u[XLEN-1];
        entry_next.dvsr = (sgn_div && b_u[XLEN-1]) ? -b_u : b_u;
        entry_next.rem = '0;
        entry_next.quo = (sgn_div && a_u[XLEN-1]) ? -a_u : a_u;
        entry_next.res = res_next;
        entry_next.fault = (s_kind == KIND_INDEX) && (a_u >= b_u);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DIV_STAGES; i++) pvalid_reg[i] <= 1'b0;
        end else if (adv) begin
            pvalid_reg[0] <= s_valid;
            for (int i = 0; i < DIV_STAGES; i++) pvalid_reg[i+1] <= pvalid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0] <= entry_next;
            for (int i = 0; i < DIV_STAGES; i++) pipe_reg[i+1] <= div_step(pipe_reg[i]);
        end
    end

    assign last = pipe_reg[DIV_STAGES];

    always_comb begin
        fin_res = last.res;
        if (last.kind == KIND_MULDIV) begin
            unique case (last.op)
                MD_DIVU, MD_DIV: begin
                    if (last.div_zero) fin_res = '1;
                    else fin_res = last.neg_quo ? -last.quo : last.quo;
                end
                MD_REMU, MD_REM: begin
                    if (last.div_zero) fin_res = last.dividend_raw;
                    else fin_res = last.neg_rem ? -last.rem : last.rem;
                end
                default: fin_res = last.res;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= pvalid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_reg <= fin_res;
            m_fault_reg <= last.fault;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_index_fault = m_fault_reg;

    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && pvalid_reg[DIV_STAGES] |=> m_valid_reg)
        else $error("last pipeline stage did not reach output");
    a_hold_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(pvalid_reg[0]) && $stable(pvalid_reg[DIV_STAGES]))
        else $error("pipeline moved during stall");
    a_fault_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        pvalid_reg[DIV_STAGES] && last.fault |-> last.kind == KIND_INDEX)
        else $error("index fault on non-index transaction");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule

>>> test/integer_execute_unit_tb.sv
// Self-checking testbench for the integer execute unit: directed table plus random traffic.
`timescale 1ns / 1ps
module integer_execute_unit_tb;
    import ieu_pkg::*;

    localparam int LATENCY = 34;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DIRECTED_ITEMS = 25;
    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    // Unassigned op codes
    localparam logic [2:0] MD_SPARE = 3'd2;
    localparam logic [2:0] BR_SPARE = 3'd7;
    localparam logic [2:0] IDX_SPARE = 3'd5;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [1:0]  shv;
    } instr_t;

    typedef struct {
        logic [31:0] result;
        logic        fault;
    } outcome_t;

    typedef struct {
        instr_t   ins;
        bit       known;
        outcome_t res;
    } vector_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [2:0]  s_op = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic [1:0]  s_shift_variant = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_result;
    logic        m_index_fault;

    outcome_t pending_results[$];
    int  error_count = 0;
    int  idle_phase = 0;      // 0: sender light, 1: receiver light, 2: none
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;

    integer_execute_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic slt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic outcome_t execute(instr_t i);
        outcome_t    o;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        logic [63:0] prod;
        logic [4:0]  n;
        o.result = '0;
        o.fault = 1'b0;
        n = i.b[4:0];
        case (i.kind)
            KIND_ARITH: case (i.op)
                ALU_AND: o.result = i.a & i.b;
                ALU_OR: o.result = i.a | i.b;
                ALU_XOR: o.result = i.a ^ i.b;
                ALU_SHIFT: case (i.shv)
                    SHV_LEFT: o.result = i.a << n;
                    SHV_LOGIC_RIGHT: o.result = i.a >> n;
                    SHV_ARITH_RIGHT: o.result = $signed(i.a) >>> n;
                    default: o.result = '0;
                endcase
                ALU_ADD: o.result = i.a + i.b;
                ALU_SUB: o.result = i.a - i.b;
                ALU_SLT: o.result = {31'd0, slt(i.a, i.b)};
                default: o.result = {31'd0, i.a < i.b};
            endcase
            KIND_MULDIV: begin
                ma = i.a[31] ? -i.a : i.a;
                mb = i.b[31] ? -i.b : i.b;
                case (i.op)
                    MD_MUL: begin
                        prod = {32'd0, i.a} * {32'd0, i.b};
                        o.result = prod[31:0];
                    end
                    MD_DIVU: o.result = (i.b == 0) ? ALL_ONES : i.a / i.b;
                    MD_REMU: o.result = (i.b == 0) ? i.a : i.a % i.b;
                    MD_DIV: begin
                        if (i.b == 0) begin
                            o.result = ALL_ONES;
                        end else begin
                            q = ma / mb;
                            o.result = (i.a[31] != i.b[31]) ? -q : q;
                        end
                    end
                    MD_REM: begin
                        if (i.b == 0) begin
                            o.result = i.a;
                        end else begin
                            r = ma % mb;
                            o.result = i.a[31] ? -r : r;
                        end
                    end
                    default: o.result = '0;
                endcase
            end
            KIND_BRANCH: case (i.op)
                BR_EQ: o.result = {31'd0, i.a == i.b};
                BR_NE: o.result = {31'd0, i.a != i.b};
                BR_LT: o.result = {31'd0, slt(i.a, i.b)};
                BR_GE: o.result = {31'd0, !slt(i.a, i.b)};
                BR_LTU: o.result = {31'd0, i.a < i.b};
                BR_GEU: o.result = {31'd0, i.a >= i.b};
                default: o.result = 32'd1;
            endcase
            default: begin
                o.fault = i.a >= i.b;
                case (i.op)
                    IDX_X1: o.result = i.a;
                    IDX_X2: o.result = i.a << 1;
                    IDX_X4: o.result = i.a << 2;
                    default: o.result = '0;
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return MIN_INT;
            3: return MAX_INT;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic vector_t row(logic [1:0] k, logic [2:0] op, logic [31:0] a,
                                    logic [31:0] b, logic [1:0] v, bit known,
                                    logic [31:0] r, logic f);
        vector_t t;
        t.ins = '{k, op, a, b, v};
        t.known = known;
        t.res = '{r, f};
        return t;
    endfunction

    // Sender: one transaction per call, valid held until accepted.
    task automatic send(instr_t i);
        while (((idle_phase == 0) && ($urandom_range(0, 99) < 7)) ||
               ((idle_phase == 1) && ($urandom_range(0, 99) < 59))) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= i.kind;
        s_op <= i.op;
        s_operand_a <= i.a;
        s_operand_b <= i.b;
        s_shift_variant <= i.shv;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Expectations enter on the input handshake.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_results.push_back(execute('{s_kind, s_op, s_operand_a,
                                               s_operand_b, s_shift_variant}));
    end

    // Receiver: random backpressure in phases 0 and 1, always ready in phase 2, plus one long hold-off.
    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else if (idle_phase == 0)
            m_ready <= ($urandom_range(0, 99) >= 59);
        else if (idle_phase == 1)
            m_ready <= ($urandom_range(0, 99) >= 7);
        else
            m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding: %h", m_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result !== want.result) begin
                    $error("result: expected %h, actual %h", want.result, m_result);
                    error_count++;
                end
                if (m_index_fault !== want.fault) begin
                    $error("index_fault: expected %b, actual %b", want.fault,
                           m_index_fault);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("integer_execute_unit verification failed");
            $finish;
        end
    end

    // Long receiver stall while the sender keeps going.
    initial begin
        wait (aresetn);
        repeat (300) @(posedge aclk);
        hold_off = 1'b1;
        repeat (200) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        vector_t     directed[DIRECTED_ITEMS];
        instr_t      ins;
        outcome_t    got;
        int          k;
        int          drain;
        directed[0] = row(KIND_ARITH, ALU_AND, ALL_ONES, 32'h0f0f_0f0f, 0, 1,
                          32'h0f0f_0f0f, 0);
        directed[1] = row(KIND_ARITH, ALU_OR, MIN_INT, MAX_INT, 0, 1, ALL_ONES, 0);
        directed[2] = row(KIND_ARITH, ALU_XOR, ALL_ONES, ALL_ONES, 3, 1, 0, 0);
        directed[3] = row(KIND_ARITH, ALU_SHIFT, 32'd1, 32'd31, SHV_LEFT, 1, MIN_INT, 0);
        directed[4] = row(KIND_ARITH, ALU_SHIFT, ALL_ONES, 32'd4, SHV_ZERO, 1, 0, 0);
        directed[5] = row(KIND_ARITH, ALU_SHIFT, MIN_INT, 32'd31, SHV_LOGIC_RIGHT, 1,
                          32'd1, 0);
        directed[6] = row(KIND_ARITH, ALU_SHIFT, MIN_INT, 32'd63, SHV_ARITH_RIGHT, 1,
                          ALL_ONES, 0);
        directed[7] = row(KIND_ARITH, ALU_ADD, MAX_INT, 32'd1, 0, 1, MIN_INT, 0);
        directed[8] = row(KIND_ARITH, ALU_SUB, MIN_INT, 32'd1, 0, 1, MAX_INT, 0);
        directed[9] = row(KIND_ARITH, ALU_SLT, MIN_INT, MAX_INT, 0, 1, 32'd1, 0);
        directed[10] = row(KIND_ARITH, ALU_SLTU, MIN_INT, MAX_INT, 0, 1, 0, 0);
        directed[11] = row(KIND_MULDIV, MD_MUL, ALL_ONES, ALL_ONES, 0, 1, 32'd1, 0);
        directed[12] = row(KIND_MULDIV, MD_DIVU, 32'd77, 0, 0, 1, ALL_ONES, 0);
        directed[13] = row(KIND_MULDIV, MD_DIV, MIN_INT, 0, 0, 1, ALL_ONES, 0);
        directed[14] = row(KIND_MULDIV, MD_REMU, 32'd77, 0, 0, 1, 32'd77, 0);
        directed[15] = row(KIND_MULDIV, MD_REM, MIN_INT, 0, 0, 1, MIN_INT, 0);
        directed[16] = row(KIND_MULDIV, MD_DIV, MIN_INT, ALL_ONES, 0, 1, MIN_INT, 0);
        directed[17] = row(KIND_MULDIV, MD_REM, MIN_INT, ALL_ONES, 0, 1, 0, 0);
        directed[18] = row(KIND_MULDIV, MD_SPARE, 32'd5, 32'd5, 0, 1, 0, 0);
        directed[19] = row(KIND_MULDIV, MD_DIV, -32'sd7, 32'd2, 0, 0, 0, 0);
        directed[20] = row(KIND_MULDIV, MD_REM, -32'sd7, 32'd2, 0, 0, 0, 0);
        directed[21] = row(KIND_BRANCH, BR_SPARE, 32'd1, 32'd2, 0, 1, 32'd1, 0);
        directed[22] = row(KIND_BRANCH, BR_GE, MIN_INT, MAX_INT, 0, 1, 0, 0);
        directed[23] = row(KIND_INDEX, IDX_X4, MIN_INT, MIN_INT, 0, 1, 0, 1);
        directed[24] = row(KIND_INDEX, IDX_SPARE, 32'd3, 32'd4, 0, 1, 0, 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Typed-in rows marked known must agree with the predictor too.
        foreach (directed[i]) begin
            got = execute(directed[i].ins);
            if (directed[i].known && ((got.result !== directed[i].res.result) ||
                                      (got.fault !== directed[i].res.fault))) begin
                $error("predictor row %0d: expected %h/%b, computed %h/%b", i,
                       directed[i].res.result, directed[i].res.fault,
                       got.result, got.fault);
                error_count++;
            end
            send(directed[i].ins);
        end

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            idle_phase = (k < RANDOM_ITEMS / 3) ? 0 :
                         (k < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            ins.kind = $urandom_range(0, 3);
            ins.op = $urandom_range(0, 7);
            ins.a = pick_operand();
            ins.b = pick_operand();
            ins.shv = $urandom_range(0, 3);
            send(ins);
        end
        s_valid <= 1'b0;

        drain = 0;
        while ((pending_results.size() != 0) && (drain < STALL_LIMIT)) begin
            @(posedge aclk);
            drain++;
        end
        repeat (LATENCY + 4) @(posedge aclk);
        if ((error_count == 0) && (pending_results.size() == 0)) begin
            $display("integer_execute_unit verification clean");
        end else begin
            $display("integer_execute_unit verification failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/ieu_pkg.sv
hw/rtl/integer_execute_unit.sv
test/integer_execute_unit_tb.sv
